### design/kwc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kwc_pkg
// Shared types, operation codes and the keyword table of the keyword counter.
// ----------------------------------------------------------------------------
package kwc_pkg;

  localparam int NUM_KEYWORDS    = 21;
  localparam int MAX_KEY_LETTERS = 8;
  localparam int COUNT_BITS      = 16;

  localparam int KEY_IDX_W = 5;
  localparam int LEN_W     = $clog2(MAX_KEY_LETTERS + 1);
  localparam int TEXT_W    = 8 * MAX_KEY_LETTERS;
  localparam int CFG_W     = 4;
  localparam int CFG_IDX_W = 1;

  // operation codes
  localparam logic [1:0] OP_FEED = 2'd0;
  localparam logic [1:0] OP_EOS  = 2'd1;
  localparam logic [1:0] OP_READ = 2'd2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_MIN_LEN = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_LEN = 1'd1;

  localparam logic [CFG_W-1:0] MIN_LEN_RESET = 4'd2;
  localparam logic [CFG_W-1:0] MAX_LEN_RESET = 4'd8;

  typedef logic [TEXT_W-1:0] kw_text_t;
  typedef logic [LEN_W-1:0]  kw_len_t;

  // Letters are kept with the first letter in the highest used byte, zero
  // padded above, which is how a string literal packs into a vector.
  localparam kw_text_t KW_TEXT [NUM_KEYWORDS] = '{
    "auto", "break", "case", "char", "const",
    "continue", "default", "define", "do", "enum",
    "float", "for", "int", "long", "main",
    "signed", "struct", "unsigned", "void",
    "volatile", "while"
  };

  localparam kw_len_t KW_LEN [NUM_KEYWORDS] = '{
    4'd4, 4'd5, 4'd4, 4'd4, 4'd5,
    4'd8, 4'd7, 4'd6, 4'd2, 4'd4,
    4'd5, 4'd3, 4'd3, 4'd4, 4'd4,
    4'd6, 4'd6, 4'd8, 4'd4,
    4'd8, 4'd5
  };

  typedef struct packed {
    logic [1:0]           operation;
    logic [7:0]           data_byte;
    logic [KEY_IDX_W-1:0] key_index;
  } req_t;

  typedef struct packed {
    logic                 word_matched;
    logic [KEY_IDX_W-1:0] matched_index;
    logic [15:0]          count_value;
  } rsp_t;

  // command handed from the tokenizer to the counter bank
  typedef struct packed {
    logic                 word_matched;
    logic [KEY_IDX_W-1:0] matched_index;
    logic                 do_read;
    logic [KEY_IDX_W-1:0] key_index;
  } cmd_t;

endpackage

### design/keyword_token_counter_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// keyword_token_counter_top
// C keyword frequency counter over a text byte stream.
// ----------------------------------------------------------------------------
// The block takes one request per clock while req_ready is high and returns
// exactly one response per request, in order. A request feeds a text byte,
// marks end of stream, or reads one keyword count. Letters gather into a
// word; a non-letter or end of stream closes it, and a closed word of allowed
// length that equals one of the 21 table words bumps that word's 16-bit
// saturating count. Words over 8 letters never match. The tokenizer's table
// compare is combinational, and the counter bank does a read-modify-write per
// command. A four-entry command queue registers each command and decouples
// the two halves; the response is registered from its head when the response
// side is not stalled, and req_ready drops only once that queue is full. The
// user must write the length bounds through cfg_we, cfg_index and cfg_data
// only while no request is in flight; the block does not enforce this.
// ----------------------------------------------------------------------------
module keyword_token_counter_top (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [kwc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [kwc_pkg::CFG_W-1:0]     cfg_data,
  input  logic                          req_valid,
  output logic                          req_ready,
  input  kwc_pkg::req_t                 req,
  output logic                          rsp_valid,
  input  logic                          rsp_ready,
  output kwc_pkg::rsp_t                 rsp
);
  import kwc_pkg::*;

  logic accept;
  logic full;
  logic empty;
  logic pop;
  cmd_t push_cmd;
  cmd_t pop_cmd;

  // every accepted request pushes exactly one command
  assign req_ready = !full;
  assign accept    = req_valid && req_ready;

  kwc_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .accept    (accept),
    .req       (req),
    .cmd       (push_cmd)
  );

  kwc_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (accept),
    .push_cmd (push_cmd),
    .full     (full),
    .pop      (pop),
    .pop_cmd  (pop_cmd),
    .empty    (empty)
  );

  kwc_back u_back (
    .clk       (clk),
    .rst       (rst),
    .empty     (empty),
    .cmd       (pop_cmd),
    .pop       (pop),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

endmodule

### design/kwc_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kwc_front
// Tokenizer: gathers letters into words, matches finished words against the
// keyword table and issues one command per request.
// ----------------------------------------------------------------------------
module kwc_front (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [kwc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [kwc_pkg::CFG_W-1:0]     cfg_data,
  input  logic                          accept,
  input  kwc_pkg::req_t                 req,
  output kwc_pkg::cmd_t                 cmd
);
  import kwc_pkg::*;

  logic [CFG_W-1:0] min_len;
  logic [CFG_W-1:0] max_len;
  kw_text_t         letters;
  kw_len_t          length;
  logic             too_long;

  logic                 is_letter;
  logic                 word_end;
  logic                 len_ok;
  logic                 hit;
  logic [KEY_IDX_W-1:0] hit_index;

  always_comb begin
    is_letter = (req.data_byte >= 8'h41 && req.data_byte <= 8'h5a) ||
                (req.data_byte >= 8'h61 && req.data_byte <= 8'h7a);
    word_end  = (req.operation == OP_EOS) || (req.operation == OP_FEED && !is_letter);
    len_ok    = !too_long && (length != '0) && (length >= min_len) && (length <= max_len);
  end

  // parallel compare against every table entry, lowest position wins
  always_comb begin
    hit       = 1'b0;
    hit_index = '0;
    for (int i = NUM_KEYWORDS - 1; i >= 0; i--) begin
      if (len_ok && length == KW_LEN[i] && letters == KW_TEXT[i]) begin
        hit       = 1'b1;
        hit_index = KEY_IDX_W'(i);
      end
    end
  end

  always_comb begin
    cmd.word_matched  = word_end && hit;
    cmd.matched_index = (word_end && hit) ? hit_index : '0;
    cmd.do_read       = (req.operation == OP_READ);
    cmd.key_index     = req.key_index;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      min_len  <= MIN_LEN_RESET;
      max_len  <= MAX_LEN_RESET;
      letters  <= '0;
      length   <= '0;
      too_long <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_MIN_LEN: min_len <= cfg_data;
          REG_MAX_LEN: max_len <= cfg_data;
          default: ;
        endcase
      end
      if (accept) begin
        if (word_end) begin
          letters  <= '0;
          length   <= '0;
          too_long <= 1'b0;
        end else if (req.operation == OP_FEED) begin
          // letter: shift in, or mark the word as over-long
          if (length < LEN_W'(MAX_KEY_LETTERS)) begin
            letters <= {letters[TEXT_W-9:0], req.data_byte};
            length  <= length + 1'b1;
          end else begin
            too_long <= 1'b1;
          end
        end
      end
    end
  end

endmodule

### design/kwc_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kwc_fifo
// Four-entry command queue between the tokenizer and the counter bank.
// ----------------------------------------------------------------------------
module kwc_fifo (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  kwc_pkg::cmd_t push_cmd,
  output logic          full,
  input  logic          pop,
  output kwc_pkg::cmd_t pop_cmd,
  output logic          empty
);
  import kwc_pkg::*;

  localparam int DEPTH = 4;
  localparam int PTR_W = $clog2(DEPTH);

  cmd_t             entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [PTR_W:0]   count;

  assign full    = (count == (PTR_W + 1)'(DEPTH));
  assign empty   = (count == '0);
  assign pop_cmd = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

### design/kwc_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kwc_back
// Counter bank: applies saturating increments and count reads in queue
// order, and holds the response register.
// ----------------------------------------------------------------------------
module kwc_back (
  input  logic          clk,
  input  logic          rst,
  input  logic          empty,
  input  kwc_pkg::cmd_t cmd,
  output logic          pop,
  output logic          rsp_valid,
  input  logic          rsp_ready,
  output kwc_pkg::rsp_t rsp
);
  import kwc_pkg::*;

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

  logic [COUNT_BITS-1:0] counts [NUM_KEYWORDS];

  logic [KEY_IDX_W-1:0]  idx;
  logic                  in_range;
  logic [COUNT_BITS-1:0] cur;

  assign pop = !empty && (!rsp_valid || rsp_ready);

  always_comb begin
    idx      = cmd.do_read ? cmd.key_index : cmd.matched_index;
    in_range = (idx < KEY_IDX_W'(NUM_KEYWORDS));
    cur      = in_range ? counts[idx] : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_KEYWORDS; i++) counts[i] <= '0;
    end else if (pop && cmd.word_matched && in_range && cur != COUNT_MAX) begin
      counts[idx] <= cur + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (pop) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      rsp.word_matched  <= cmd.word_matched;
      rsp.matched_index <= cmd.matched_index;
      rsp.count_value   <= cmd.do_read ? 16'(cur) : '0;
    end
  end

endmodule
